### sv/ate_pkg.sv
// Package for the terminal escape parser: command codes, parse modes, byte constants.
// No dependencies.
`default_nettype none
package ate_pkg;
    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_SCROLL = 2'd1;
    localparam logic [1:0] CMD_CLR_RANGE = 2'd2;
    localparam logic [1:0] CMD_CLR_RECT = 2'd3;

    localparam logic [7:0] CH_BEL = 8'h07;
    localparam logic [7:0] CH_BS = 8'h08;
    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_ESC = 8'h1B;
    localparam logic [7:0] CH_ST = 8'h9C;
    localparam logic [7:0] CH_BSL = 8'h5C;

    localparam logic [13:0] PARAM_MAX = 14'd9999;

    localparam logic [1:0] REG_WIDTH = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_DEF_FG = 2'd2;
    localparam logic [1:0] REG_DEF_BG = 2'd3;

    typedef enum logic [4:0] {
        M_GROUND = 5'b00001,
        M_ESC = 5'b00010,
        M_CHARSET = 5'b00100,
        M_OSC = 5'b01000,
        M_CSI = 5'b10000
    } t_mode;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_DECODE = 6'b000010,
        S_SGR = 6'b000100,
        S_OUT1 = 6'b001000,
        S_OUT2 = 6'b010000,
        S_WRAP = 6'b100000
    } t_seq;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] row_a;
        logic [7:0] col_a;
        logic [7:0] row_b;
        logic [7:0] col_b;
        logic [7:0] glyph;
    } t_cmd;
endpackage
`default_nettype wire

### sv/ansi_terminal_escape_parser.sv
// Terminal escape parser top level: sequencer, parameter memory, output register.
// Depends on ate_pkg.
// Sequence: a byte is accepted in IDLE; an escape-mode byte then runs DECODE and OUT1,
// a ground byte runs WRAP before DECODE, and a second command adds OUT2.
// CSI 'm' walks the stored parameters one per cycle through a range compare function
// in SGR, between DECODE and OUT1.
// A receiver that holds off a pending command stalls OUT1 or OUT2. One byte in flight.
// Reset (synchronous, active low) restores the register defaults, ground mode,
// home cursor, default colors and an empty parameter list.
`default_nettype none
module ansi_terminal_escape_parser
    import ate_pkg::*;
#(
    parameter int MAX_PARAMS = 16
) (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic psel,
    input wire logic penable,
    input wire logic pwrite,
    input wire logic [3:0] paddr,
    input wire logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic pready,
    input wire logic i_valid,
    output logic o_ready,
    input wire logic [7:0] i_char_code,
    output logic o_valid,
    input wire logic i_ready,
    output logic [1:0] o_cmd,
    output logic [7:0] o_row_a,
    output logic [7:0] o_col_a,
    output logic [7:0] o_row_b,
    output logic [7:0] o_col_b,
    output logic [7:0] o_glyph,
    output logic [2:0] o_fg_color,
    output logic [2:0] o_bg_color,
    output logic o_reverse_video,
    output logic o_last
);
    localparam int PW = $clog2(MAX_PARAMS);
    localparam int CW = $clog2(MAX_PARAMS + 1);
    localparam logic [CW-1:0] PMAX = CW'(MAX_PARAMS);

    // configuration registers
    logic [7:0] r_width, r_height;
    logic [2:0] r_def_fg, r_def_bg;
    logic cfg_wr;
    logic [1:0] cfg_idx;
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign cfg_idx = paddr[3:2];
    always_comb begin
        unique case (cfg_idx)
            REG_WIDTH: prdata = {24'd0, r_width};
            REG_HEIGHT: prdata = {24'd0, r_height};
            REG_DEF_FG: prdata = {29'd0, r_def_fg};
            default: prdata = {29'd0, r_def_bg};
        endcase
    end

    // effective screen size, 9 bits
    logic [8:0] w, h;
    assign w = (r_width == 8'd0) ? 9'd1 : {1'b0, r_width};
    assign h = (r_height == 8'd0) ? 9'd1 : {1'b0, r_height};

    t_seq r_seq;
    t_mode r_mode;
    logic [7:0] r_ch;
    logic [8:0] r_row, r_col;
    logic [2:0] r_fg, r_bg;
    logic r_rev;
    logic [CW-1:0] r_pcnt, r_pidx;
    logic [13:0] r_acc;
    t_cmd r_c1, r_c2;
    logic r_has1, r_has2;

    // parameter memory; entries past r_pcnt read as 0 by the count
    logic [13:0] r_pmem [MAX_PARAMS];
    logic [13:0] r_prd;
    logic pm_we;
    logic [PW-1:0] pm_wa, pm_ra;
    always_ff @(posedge i_clk) begin
        if (pm_we) r_pmem[pm_wa] <= r_acc;
        r_prd <= r_pmem[pm_ra];
    end

    assign o_ready = (r_seq == S_IDLE);
    logic in_acc;
    assign in_acc = i_valid && o_ready;

    // range compare function over a 14-bit value
    function automatic logic in_rng(input logic [13:0] v, input int lo, input int hi);
        in_rng = (v >= 14'(lo)) && (v <= 14'(hi));
    endfunction

    // p0 is held in r_p0 once read at decode; p1 captured too
    logic [13:0] r_p0, r_p1;
    logic [13:0] acc_next;
    logic [17:0] acc_mul;
    assign acc_mul = {r_acc, 3'b000} + {3'b000, r_acc, 1'b0} + {10'd0, r_ch - 8'h30};
    assign acc_next = (acc_mul > 18'(PARAM_MAX)) ? PARAM_MAX : acc_mul[13:0];

    logic is_digit;
    assign is_digit = (r_ch >= 8'h30) && (r_ch <= 8'h39);

    // p0/p1 including the parameter that this terminator stores
    logic store_now;
    logic [CW-1:0] cnt_after;
    assign store_now = (r_pcnt < PMAX);
    assign cnt_after = store_now ? r_pcnt + 1'b1 : r_pcnt;
    logic [13:0] p0, p1;
    assign p0 = (cnt_after == '0) ? 14'd0 : (r_pcnt == '0) ? r_acc : r_p0;
    assign p1 = (cnt_after < CW'(2)) ? 14'd0 : (r_pcnt == CW'(1)) ? r_acc : r_p1;

    always_comb begin
        pm_we = 1'b0;
        pm_wa = r_pcnt[PW-1:0];
        pm_ra = r_pidx[PW-1:0];
        if (r_seq == S_DECODE && r_mode == M_CSI && !is_digit && r_ch != 8'h3F
            && store_now) pm_we = 1'b1;
    end

    logic [8:0] kcnt0, kcnt1, hr, hc;
    assign kcnt0 = (w > r_col) ? w - r_col : 9'd0;
    assign kcnt1 = (r_col >= 9'd255) ? 9'd255 : r_col + 9'd1;
    assign hr = (p0 == 14'd0) ? 9'd1 : (p0 > 14'(h)) ? h : p0[8:0];
    assign hc = (p1 == 14'd0) ? 9'd1 : (p1 > 14'(w)) ? w : p1[8:0];

    // output valid: set when OUT1 loads a command, cleared once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (r_seq == S_OUT1 && (!o_valid || i_ready)) begin
            o_valid <= r_has1;
        end else if (r_seq != S_OUT2 && o_valid && i_ready) begin
            o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width <= 8'd80;
            r_height <= 8'd24;
            r_def_fg <= 3'd7;
            r_def_bg <= 3'd0;
            r_seq <= S_IDLE;
            r_mode <= M_GROUND;
            r_row <= '0;
            r_col <= '0;
            r_fg <= 3'd7;
            r_bg <= 3'd0;
            r_rev <= 1'b0;
            r_pcnt <= '0;
            r_pidx <= '0;
            r_acc <= '0;
            r_has1 <= 1'b0;
            r_has2 <= 1'b0;
        end else begin
            if (cfg_wr) begin
                unique case (cfg_idx)
                    REG_WIDTH: r_width <= pwdata[7:0];
                    REG_HEIGHT: r_height <= pwdata[7:0];
                    REG_DEF_FG: r_def_fg <= pwdata[2:0];
                    default: r_def_bg <= pwdata[2:0];
                endcase
            end
            unique case (r_seq)
                S_IDLE: begin
                    if (in_acc) begin
                        r_ch <= i_char_code;
                        r_has1 <= 1'b0;
                        r_has2 <= 1'b0;
                        r_seq <= (r_mode == M_GROUND) ? S_WRAP : S_DECODE;
                    end
                end
                S_WRAP: begin
                    // wrap and scroll before the ground byte acts
                    if (r_col >= w) begin
                        r_col <= '0;
                        if (r_row + 9'd1 >= h) begin
                            r_row <= h - 9'd1;
                            r_has1 <= 1'b1;
                            r_c1 <= '{CMD_SCROLL, 8'd0, 8'd0, 8'(h - 9'd1), 8'd0, 8'd0};
                        end else r_row <= r_row + 9'd1;
                    end else if (r_row >= h) begin
                        r_row <= h - 9'd1;
                        r_has1 <= 1'b1;
                        r_c1 <= '{CMD_SCROLL, 8'd0, 8'd0, 8'(h - 9'd1), 8'd0, 8'd0};
                    end
                    r_seq <= S_DECODE;
                end
                S_DECODE: begin
                    r_seq <= (r_mode == M_CSI && r_ch == 8'h6D) ? S_SGR : S_OUT1;
                    priority case (1'b1)
                        r_mode == M_GROUND: begin
                            priority if (r_ch == CH_BEL) begin
                            end else if (r_ch == CH_BS) begin
                                if (r_col != '0) r_col <= r_col - 9'd1;
                            end else if (r_ch == CH_CR) begin
                                r_col <= '0;
                            end else if (r_ch == CH_LF) begin
                                if (r_row != 9'd511) r_row <= r_row + 9'd1;
                            end else if (r_ch == CH_ESC) begin
                                r_mode <= M_ESC;
                            end else begin
                                if (r_has1) begin
                                    r_has2 <= 1'b1;
                                    r_c2 <= '{CMD_WRITE, r_row[7:0], r_col[7:0], 8'd0, 8'd0, r_ch};
                                end else begin
                                    r_has1 <= 1'b1;
                                    r_c1 <= '{CMD_WRITE, r_row[7:0], r_col[7:0], 8'd0, 8'd0, r_ch};
                                end
                                if (r_col != 9'd511) r_col <= r_col + 9'd1;
                            end
                        end
                        r_mode == M_ESC: begin
                            if (r_ch == 8'h28) r_mode <= M_CHARSET;
                            else if (r_ch == 8'h5D) r_mode <= M_OSC;
                            else if (r_ch == 8'h5B) r_mode <= M_CSI;
                            else r_mode <= M_GROUND;
                        end
                        r_mode == M_CHARSET: r_mode <= M_GROUND;
                        r_mode == M_OSC: begin
                            if (r_ch == CH_ST || r_ch == CH_BSL || r_ch == CH_BEL)
                                r_mode <= M_GROUND;
                        end
                        default: begin
                            if (r_ch == 8'h3F) begin
                            end else if (is_digit) begin
                                r_acc <= acc_next;
                            end else begin
                                if (r_pcnt == '0) r_p0 <= r_acc;
                                if (r_pcnt == CW'(1)) r_p1 <= r_acc;
                                r_acc <= '0;
                                if (r_ch == 8'h3B) begin
                                    r_pcnt <= cnt_after;
                                end else begin
                                    r_mode <= M_GROUND;
                                    if (r_ch == 8'h6D) begin
                                        r_pidx <= '0;
                                        r_pcnt <= cnt_after;
                                    end else begin
                                        r_pcnt <= '0;
                                        if (r_ch == 8'h48) begin
                                            r_row <= hr - 9'd1;
                                            r_col <= hc - 9'd1;
                                        end else if (r_ch == 8'h4A) begin
                                            r_has1 <= (p0 <= 14'd2);
                                            if (p0 == 14'd0)
                                                r_c1 <= '{CMD_CLR_RANGE, r_row[7:0], r_col[7:0],
                                                    8'(h - 9'd1), 8'(w - 9'd1), 8'd0};
                                            else if (p0 == 14'd1)
                                                r_c1 <= '{CMD_CLR_RANGE, 8'd0, 8'd0,
                                                    r_row[7:0], r_col[7:0], 8'd0};
                                            else
                                                r_c1 <= '{CMD_CLR_RECT, 8'd0, 8'd0,
                                                    h[7:0], w[7:0], 8'd0};
                                        end else if (r_ch == 8'h4B) begin
                                            r_has1 <= (p0 <= 14'd2);
                                            if (p0 == 14'd0)
                                                r_c1 <= '{CMD_CLR_RECT, r_row[7:0], r_col[7:0],
                                                    8'd1, kcnt0[7:0], 8'd0};
                                            else if (p0 == 14'd1)
                                                r_c1 <= '{CMD_CLR_RECT, r_row[7:0], 8'd0,
                                                    8'd1, kcnt1[7:0], 8'd0};
                                            else
                                                r_c1 <= '{CMD_CLR_RECT, r_row[7:0], 8'd0,
                                                    8'd1, w[7:0], 8'd0};
                                        end
                                    end
                                end
                            end
                        end
                    endcase
                end
                S_SGR: begin
                    // memory read is registered: r_prd holds the entry just below r_pidx
                    if (r_pidx != '0) begin
                        if (r_prd == 14'd0) begin
                            r_fg <= r_def_fg;
                            r_bg <= r_def_bg;
                            r_rev <= 1'b0;
                        end else if (in_rng(r_prd, 30, 37)) r_fg <= 3'(r_prd - 14'd30);
                        else if (in_rng(r_prd, 40, 47)) r_bg <= 3'(r_prd - 14'd40);
                        else if (r_prd == 14'd7) r_rev <= 1'b1;
                        else if (r_prd == 14'd27) r_rev <= 1'b0;
                    end
                    if (r_pidx == r_pcnt) begin
                        r_pcnt <= '0;
                        r_seq <= S_OUT1;
                    end else r_pidx <= r_pidx + 1'b1;
                end
                S_OUT1: begin
                    if (!o_valid || i_ready) begin
                        if (r_has1) begin
                            {o_cmd, o_row_a, o_col_a, o_row_b, o_col_b, o_glyph} <= r_c1;
                            o_fg_color <= r_fg;
                            o_bg_color <= r_bg;
                            o_reverse_video <= r_rev;
                            o_last <= !r_has2;
                            r_seq <= r_has2 ? S_OUT2 : S_IDLE;
                        end else begin
                            r_seq <= S_IDLE;
                        end
                    end
                end
                default: begin
                    if (i_ready) begin
                        {o_cmd, o_row_a, o_col_a, o_row_b, o_col_b, o_glyph} <= r_c2;
                        o_last <= 1'b1;
                        r_seq <= S_IDLE;
                    end
                end
            endcase
        end
    end
endmodule
`default_nettype wire

### tb/ate_checker.sv
// Scoreboard for the terminal escape parser: watches both channels, predicts commands.
// Depends on ate_pkg; configuration is mirrored from the APB write strobes.
`default_nettype none
module ate_checker
    import ate_pkg::*;
#(
    parameter int MAX_PARAMS = 16
) (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic psel,
    input wire logic penable,
    input wire logic pwrite,
    input wire logic pready,
    input wire logic [3:0] paddr,
    input wire logic [31:0] pwdata,
    input wire logic i_valid,
    input wire logic o_ready,
    input wire logic [7:0] i_char_code,
    input wire logic o_valid,
    input wire logic i_ready,
    input wire logic [1:0] o_cmd,
    input wire logic [7:0] o_row_a,
    input wire logic [7:0] o_col_a,
    input wire logic [7:0] o_row_b,
    input wire logic [7:0] o_col_b,
    input wire logic [7:0] o_glyph,
    input wire logic [2:0] o_fg_color,
    input wire logic [2:0] o_bg_color,
    input wire logic o_reverse_video,
    input wire logic o_last,
    output int errors,
    output int pending,
    output int n_cmds
);
    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] ra, ca, rb, cb, glyph;
        logic [2:0] fg, bg;
        logic rev, last;
    } t_disp;

    typedef enum logic [2:0] {P_GROUND, P_ESC, P_CHARSET, P_OSC, P_CSI} t_pmode;

    t_disp disp_q[$];
    t_disp step_q[$];

    logic [7:0] cfg_w, cfg_h;
    logic [2:0] cfg_fg, cfg_bg;
    t_pmode pmode;
    int unsigned cur_row, cur_col, acc, nparm;
    int unsigned parms[MAX_PARAMS];
    logic [2:0] cur_fg, cur_bg;
    logic cur_rev;

    assign pending = disp_q.size();

    function automatic int unsigned parm(int unsigned i);
        return (i < nparm && i < MAX_PARAMS) ? parms[i] : 0;
    endfunction

    task automatic push_cmd(logic [1:0] c, int unsigned ra, int unsigned ca,
                            int unsigned rb, int unsigned cb, int unsigned g);
        t_disp d;
        d.cmd = c; d.ra = ra[7:0]; d.ca = ca[7:0]; d.rb = rb[7:0]; d.cb = cb[7:0];
        d.glyph = g[7:0]; d.fg = cur_fg; d.bg = cur_bg; d.rev = cur_rev; d.last = 1'b0;
        step_q.push_back(d);
    endtask

    task automatic parse_byte(logic [7:0] ch);
        int unsigned w, h, r, k, p0, v;
        w = (cfg_w == 0) ? 1 : cfg_w;
        h = (cfg_h == 0) ? 1 : cfg_h;
        step_q.delete();
        case (pmode)
            P_ESC: begin
                if (ch == "(") pmode = P_CHARSET;
                else if (ch == "]") pmode = P_OSC;
                else if (ch == "[") pmode = P_CSI;
                else pmode = P_GROUND;
            end
            P_CHARSET: pmode = P_GROUND;
            P_OSC: if (ch == CH_ST || ch == CH_BSL || ch == CH_BEL) pmode = P_GROUND;
            P_CSI: begin
                if (ch == "?") begin
                end else if (ch >= "0" && ch <= "9") begin
                    acc = acc * 10 + (ch - "0");
                    if (acc > PARAM_MAX) acc = PARAM_MAX;
                end else begin
                    if (nparm < MAX_PARAMS) begin
                        parms[nparm] = acc;
                        nparm++;
                    end
                    acc = 0;
                    if (ch != ";") begin
                        p0 = parm(0);
                        case (ch)
                            "m": for (int i = 0; i < nparm && i < MAX_PARAMS; i++) begin
                                v = parms[i];
                                if (v == 0) begin
                                    cur_fg = cfg_fg; cur_bg = cfg_bg; cur_rev = 1'b0;
                                end else if (v >= 30 && v <= 37) cur_fg = 3'(v - 30);
                                else if (v >= 40 && v <= 47) cur_bg = 3'(v - 40);
                                else if (v == 7) cur_rev = 1'b1;
                                else if (v == 27) cur_rev = 1'b0;
                            end
                            "H": begin
                                r = parm(0); k = parm(1);
                                if (r < 1) r = 1;
                                if (r > h) r = h;
                                if (k < 1) k = 1;
                                if (k > w) k = w;
                                cur_row = r - 1; cur_col = k - 1;
                            end
                            "J": begin
                                if (p0 == 0)
                                    push_cmd(CMD_CLR_RANGE, cur_row, cur_col, h - 1, w - 1, 0);
                                else if (p0 == 1)
                                    push_cmd(CMD_CLR_RANGE, 0, 0, cur_row, cur_col, 0);
                                else if (p0 == 2)
                                    push_cmd(CMD_CLR_RECT, 0, 0, h, w, 0);
                            end
                            "K": begin
                                if (p0 == 0) begin
                                    k = (w > cur_col) ? w - cur_col : 0;
                                    push_cmd(CMD_CLR_RECT, cur_row, cur_col, 1, k, 0);
                                end else if (p0 == 1) begin
                                    k = cur_col + 1;
                                    if (k > 255) k = 255;
                                    push_cmd(CMD_CLR_RECT, cur_row, 0, 1, k, 0);
                                end else if (p0 == 2) begin
                                    push_cmd(CMD_CLR_RECT, cur_row, 0, 1, w, 0);
                                end
                            end
                            default: ;
                        endcase
                        pmode = P_GROUND;
                        nparm = 0;
                        acc = 0;
                    end
                end
            end
            default: begin
                // wrap and scroll happen before the byte itself acts
                if (cur_col >= w) begin
                    cur_col = 0;
                    cur_row++;
                end
                if (cur_row >= h) begin
                    cur_row = h - 1;
                    push_cmd(CMD_SCROLL, 0, 0, h - 1, 0, 0);
                end
                case (ch)
                    CH_BEL: ;
                    CH_BS: if (cur_col >= 1) cur_col--;
                    CH_CR: cur_col = 0;
                    CH_LF: if (cur_row < 511) cur_row++;
                    CH_ESC: pmode = P_ESC;
                    default: begin
                        push_cmd(CMD_WRITE, cur_row, cur_col, 0, 0, ch);
                        if (cur_col < 511) cur_col++;
                    end
                endcase
            end
        endcase
        if (step_q.size() > 0) step_q[step_q.size() - 1].last = 1'b1;
        foreach (step_q[i]) disp_q.push_back(step_q[i]);
    endtask

    always @(posedge i_clk) begin
        t_disp got, exp_d;
        if (!i_rst_n) begin
            cfg_w <= 8'd80; cfg_h <= 8'd24; cfg_fg <= 3'd7; cfg_bg <= 3'd0;
            pmode = P_GROUND;
            cur_row = 0; cur_col = 0; acc = 0; nparm = 0;
            cur_fg = 3'd7; cur_bg = 3'd0; cur_rev = 1'b0;
            foreach (parms[i]) parms[i] = 0;
            disp_q.delete();
            errors <= 0;
            n_cmds <= 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    REG_WIDTH: cfg_w <= pwdata[7:0];
                    REG_HEIGHT: cfg_h <= pwdata[7:0];
                    REG_DEF_FG: cfg_fg <= pwdata[2:0];
                    REG_DEF_BG: cfg_bg <= pwdata[2:0];
                endcase
            end
            if (o_valid && i_ready) begin
                got = {o_cmd, o_row_a, o_col_a, o_row_b, o_col_b, o_glyph,
                       o_fg_color, o_bg_color, o_reverse_video, o_last};
                n_cmds <= n_cmds + 1;
                if (disp_q.size() == 0) begin
                    if (errors < 10) $display("unexpected command %h", got);
                    errors <= errors + 1;
                end else begin
                    exp_d = disp_q.pop_front();
                    if (got !== exp_d) begin
                        if (errors < 10)
                            $display({"mismatch: exp cmd%0d r%0d c%0d %0d/%0d g%h fg%0d bg%0d",
                                      " rv%b l%b, got cmd%0d r%0d c%0d %0d/%0d g%h fg%0d",
                                      " bg%0d rv%b l%b"},
                                     exp_d.cmd, exp_d.ra, exp_d.ca, exp_d.rb, exp_d.cb,
                                     exp_d.glyph, exp_d.fg, exp_d.bg, exp_d.rev, exp_d.last,
                                     got.cmd, got.ra, got.ca, got.rb, got.cb, got.glyph,
                                     got.fg, got.bg, got.rev, got.last);
                        errors <= errors + 1;
                    end
                end
            end
            // input handled after output: a command of an earlier byte may leave in the accept cycle
            if (i_valid && o_ready) parse_byte(i_char_code);
        end
    end
endmodule
`default_nettype wire

### tb/testbench.sv
// Top of the terminal escape parser bench: clock, reset, APB setup, byte stimulus.
// Depends on ate_pkg, ate_checker and the parser RTL.
`default_nettype none
module testbench;
    import ate_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [3:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic i_valid = 1'b0;
    logic o_ready;
    logic [7:0] i_char_code = '0;
    logic o_valid;
    logic i_ready = 1'b0;
    logic [1:0] o_cmd;
    logic [7:0] o_row_a, o_col_a, o_row_b, o_col_b, o_glyph;
    logic [2:0] o_fg_color, o_bg_color;
    logic o_reverse_video, o_last;

    int errors, pending, n_cmds;
    int n_bytes = 0;
    bit hold_off = 1'b0;      // long receiver stall in progress
    bit stim_done = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    ansi_terminal_escape_parser dut (.*);

    ate_checker chk (.*);

    // APB write: setup cycle, then access cycle; pready is always high
    task automatic reg_write(logic [1:0] idx, logic [31:0] val);
        @(negedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    // one byte transaction; valid held with stable payload until accepted
    task automatic send_byte(logic [7:0] b);
        i_valid <= 1'b1;
        i_char_code <= b;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        n_bytes++;
        @(negedge i_clk);
    endtask

    // bursty sender: short gaps between bursts of random length
    int burst_left = 0;
    task automatic put(logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 4);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        send_byte(b);
    endtask

    task automatic put_str(string s);
        for (int i = 0; i < s.len(); i++) put(s[i]);
    endtask

    task automatic put_num(int unsigned v);
        put_str($sformatf("%0d", v));
    endtask

    // idle point: wait for all commands out, then drain any silent byte
    task automatic quiesce();
        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (24) @(negedge i_clk);
    endtask

    // well-formed-ish random sequence
    task automatic rand_seq();
        int sel, np;
        sel = $urandom_range(0, 99);
        if (sel < 35) begin
            put(8'($urandom_range(32, 126)));
        end else if (sel < 45) begin
            case ($urandom_range(0, 4))
                0: put(CH_BEL);
                1: put(CH_BS);
                2: put(CH_CR);
                3: put(CH_LF);
                default: put(8'($urandom_range(0, 255)));
            endcase
        end else if (sel < 85) begin
            put(CH_ESC); put("[");
            np = $urandom_range(0, 4);
            if ($urandom_range(0, 9) == 0) put("?");
            for (int i = 0; i < np; i++) begin
                if ($urandom_range(0, 5) != 0) begin
                    case ($urandom_range(0, 3))
                        0: put_num($urandom_range(0, 2));
                        1: put_num($urandom_range(0, 50));
                        2: put_num($urandom_range(0, 300));
                        default: put_num($urandom_range(0, 99999));
                    endcase
                end
                if (i != np - 1) put(";");
            end
            case ($urandom_range(0, 9))
                0, 1, 2: put("m");
                3, 4: put("H");
                5, 6: put("J");
                7, 8: put("K");
                default: put(8'($urandom_range(0, 255)));
            endcase
        end else if (sel < 92) begin
            put(CH_ESC); put("]");
            repeat ($urandom_range(0, 6)) put(8'($urandom_range(0, 255)));
            case ($urandom_range(0, 2))
                0: put(CH_BEL);
                1: put(CH_BSL);
                default: put(CH_ST);
            endcase
        end else if (sel < 96) begin
            put(CH_ESC); put("("); put(8'($urandom_range(0, 255)));
        end else begin
            put(CH_ESC); put(8'($urandom_range(0, 255)));
        end
    endtask

    // receiver: random stall pattern, calm stretches, one long hold-off
    initial begin
        int mode;
        @(negedge i_clk);
        while (1) begin
            mode = $urandom_range(0, 3);
            repeat ($urandom_range(10, 60)) begin
                if (hold_off) i_ready <= 1'b0;
                else if (mode == 0) i_ready <= 1'b1;
                else i_ready <= ($urandom_range(0, 3) >= mode - 1);
                @(negedge i_clk);
            end
        end
    end

    initial begin
        #4000000;
        $display("timeout");
        $display("[ansi_terminal_escape_parser] ERROR");
        $finish;
    end

    initial begin
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: reset defaults first
        put_str("Hi");
        put(8'h00); put(8'hFF);
        put(CH_BS); put(CH_CR); put(CH_LF); put(CH_BEL);
        put_str("\033[7;31;42m"); put("x");
        put_str("\033[0m"); put_str("\033[27m");
        put_str("\033[99999;0H"); put("y");          // clamp row, col 0 -> 1
        put_str("\033[?J"); put_str("\033[1J"); put_str("\033[2J"); put_str("\033[3J");
        put_str("\033[K"); put_str("\033[1K"); put_str("\033[2K");
        put_str("\033]ab\x9c"); put_str("\033(B"); put_str("\033Z");
        put_str("\033[1;2;3;4;5;6;7;8;9;10;11;12;13;14;15;16;17;31m");
        put_str("\033[24;80H"); put_str("ab");        // wrap + scroll
        quiesce();

        // tiny screen, nondefault colors
        reg_write(REG_WIDTH, 1); reg_write(REG_HEIGHT, 1);
        reg_write(REG_DEF_FG, 0); reg_write(REG_DEF_BG, 7);
        put_str("\033[0mabc\033[K\033[1K\033[J");
        quiesce();
        // zero size acts as one; cursor left outside the screen by register change
        reg_write(REG_WIDTH, 255); reg_write(REG_HEIGHT, 255);
        put_str("\033[255;255H"); put("z");
        put_str("\033[250;250H");
        quiesce();
        reg_write(REG_WIDTH, 0); reg_write(REG_HEIGHT, 0);
        put_str("\033[K\033[1K\033[0J\033[1J"); put("q");
        quiesce();

        // long receiver stall while bytes keep coming
        reg_write(REG_WIDTH, 4); reg_write(REG_HEIGHT, 3);
        hold_off = 1'b1;
        fork
            begin
                repeat (300) @(negedge i_clk);
                hold_off = 1'b0;
            end
            repeat (40) put(8'($urandom_range(32, 126)));
        join
        quiesce();

        // random phases through several settings
        for (int ph = 0; ph < 6; ph++) begin
            reg_write(REG_WIDTH, (ph == 0) ? 255 : (ph == 1) ? 1 : $urandom_range(1, 40));
            reg_write(REG_HEIGHT, (ph == 0) ? 255 : (ph == 1) ? 1 : $urandom_range(1, 12));
            reg_write(REG_DEF_FG, $urandom_range(0, 7));
            reg_write(REG_DEF_BG, $urandom_range(0, 7));
            while (n_bytes < 140 + (ph + 1) * 170) rand_seq();
            quiesce();
        end
        i_valid <= 1'b0;
        stim_done = 1'b1;
    end

    initial begin
        int guard;
        wait (stim_done);
        guard = 0;
        while (pending != 0 && guard < 100000) begin
            @(negedge i_clk);
            guard++;
        end
        repeat (30) @(negedge i_clk);
        $display("covered %0d bytes producing %0d display commands across 11 screen setups",
                 n_bytes, n_cmds);
        if (errors == 0 && pending == 0) begin
            $display("[ansi_terminal_escape_parser] OK");
        end else begin
            $display("%0d mismatches, %0d commands missing", errors, pending);
            $display("[ansi_terminal_escape_parser] ERROR");
        end
        $finish;
    end
endmodule
`default_nettype wire
